/* rtl/csb_pkg.sv */
// ============================================================================
// csb_pkg
// Shared types and constants for the channel quality scoreboard.
// ============================================================================
package csb_pkg;

    // Event opcodes.
    localparam logic [2:0] OP_TX_OK   = 3'd0;
    localparam logic [2:0] OP_TX_FAIL = 3'd1;
    localparam logic [2:0] OP_RX      = 3'd2;
    localparam logic [2:0] OP_SET_CH  = 3'd3;
    localparam logic [2:0] OP_SELECT  = 3'd4;

    // Score steps, as 4-bit signed deltas.
    localparam logic signed [3:0] STEP_TX_OK   = 4'sd2;
    localparam logic signed [3:0] STEP_TX_FAIL = -4'sd8;
    localparam logic signed [3:0] STEP_RX_GOOD = 4'sd1;
    localparam logic signed [3:0] STEP_RX_WEAK = -4'sd2;
    localparam logic signed [3:0] STEP_NONE    = 4'sd0;

    // Saturation limits.
    localparam logic signed [9:0] SCORE_HI = 10'sd127;
    localparam logic signed [9:0] SCORE_LO = -10'sd127;

    // Register reset values.
    localparam logic [6:0] MIN_CH_RST   = 7'd0;
    localparam logic [6:0] MAX_CH_RST   = 7'd100;
    localparam logic [6:0] DEF_CH_RST   = 7'd0;
    localparam logic [7:0] GOOD_THR_RST = 8'hB5;   // -75 dBm
    localparam logic [7:0] WEAK_THR_RST = 8'hA6;   // -90 dBm

    // Configuration port address width (five word registers).
    localparam int APB_AW = 5;

    // Kind of result that the datapath captures on a given cycle.
    typedef enum logic [1:0] {
        RES_IDLE,
        RES_REJECT,
        RES_APPLY,
        RES_SELECT
    } t_res_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;       // latch the incoming transaction
        logic      rd_item;    // read the score of the addressed channel
        logic      rd_cur;     // read the current channel, arm the scan counter
        logic      best_init;  // seed the best score from the current channel
        logic      scan_en;    // issue scan reads and compare returned scores
        t_res_kind res;        // capture a result of this kind
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_update;   // score event or set-channel on a valid channel
        logic is_select;   // select-best event
        logic scan_busy;   // reads left to issue or a compare in flight
    } t_dp_sts;

endpackage

/* rtl/channel_quality_scoreboard.sv */
// ============================================================================
// channel_quality_scoreboard
// Keeps a saturating signed quality score per radio channel and picks the best.
// ============================================================================
// Usage:
//   Command channel: drive i_opcode, i_channel and i_rssi with start high; the
//   transaction is taken at a clock edge where start is high and busy is low.
//   busy stays high until the result is issued, so one transaction is in
//   flight at a time.
//   Result channel: o_done is high for exactly one cycle with the result
//   fields; the receiver cannot stall it and must take it in that cycle.
//   An event on an invalid channel or an unknown opcode is rejected at dispatch;
//   a score or set-channel event reads the channel's score, then writes the
//   update; a select reads the current channel, seeds the best score from it,
//   then scans the N channels of the configured window (at most CHANNEL_COUNT)
//   through the single read port of the score memory, which returns one score
//   per cycle to the compare stage. A new transaction can be taken in the cycle
//   o_done is shown. Reset clears every score (through per-entry valid bits,
//   with no clearing pass), sets the current channel to 0 and restores the
//   register defaults. Configuration goes through the APB-style port and must
//   be written while idle by the user; the block itself does not enforce this.
// ============================================================================
module channel_quality_scoreboard
    import csb_pkg::*;
#(
    parameter int CHANNEL_COUNT = 128
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_channel,
    input  logic signed [7:0] i_rssi,
    output logic              o_done,
    output logic              o_accepted,
    output logic signed [7:0] o_channel_score,
    output logic [6:0]        o_pick_channel,
    output logic signed [7:0] o_pick_score,
    output logic [6:0]        o_active_channel_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic [6:0] min_channel;
    logic [6:0] max_channel;
    logic [7:0] good_thr;
    logic [7:0] weak_thr;

    // Configuration registers.
    csb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_min_channel (min_channel),
        .o_max_channel (max_channel),
        .o_good_thr    (good_thr),
        .o_weak_thr    (weak_thr)
    );

    // Sequencer.
    csb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Score store and arithmetic.
    csb_dp #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_opcode             (i_opcode),
        .i_channel            (i_channel),
        .i_rssi               (i_rssi),
        .i_min_channel        (min_channel),
        .i_max_channel        (max_channel),
        .i_good_thr           (good_thr),
        .i_weak_thr           (weak_thr),
        .o_accepted           (o_accepted),
        .o_channel_score      (o_channel_score),
        .o_pick_channel       (o_pick_channel),
        .o_pick_score         (o_pick_score),
        .o_active_channel_out (o_active_channel_out)
    );

    // A result only follows a cycle in which a transaction was in flight.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    // An accepted transaction makes the block busy on the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    // A rejected transaction carries zero scores.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_accepted) |-> (o_channel_score == 8'sd0 && o_pick_score == 8'sd0))
        else $error("rejected result with nonzero score");

    // Only a select returns a best score, and a select has no channel score.
    a_score_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_channel_score == 8'sd0 || o_pick_score == 8'sd0))
        else $error("channel score and best score both set");

endmodule

/* rtl/csb_regs.sv */
// ============================================================================
// csb_regs
// Configuration register file behind the APB-style port.
// ============================================================================
module csb_regs
    import csb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [6:0]        o_min_channel,
    output logic [6:0]        o_max_channel,
    output logic [7:0]        o_good_thr,
    output logic [7:0]        o_weak_thr
);

    localparam logic [2:0] REG_MIN_CH   = 3'd0;
    localparam logic [2:0] REG_MAX_CH   = 3'd1;
    localparam logic [2:0] REG_DEF_CH   = 3'd2;
    localparam logic [2:0] REG_GOOD_THR = 3'd3;
    localparam logic [2:0] REG_WEAK_THR = 3'd4;

    logic [6:0] r_min_ch;
    logic [6:0] r_max_ch;
    logic [6:0] r_def_ch;
    logic [7:0] r_good_thr;
    logic [7:0] r_weak_thr;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:2];

    // Register writes on the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ch   <= MIN_CH_RST;
            r_max_ch   <= MAX_CH_RST;
            r_def_ch   <= DEF_CH_RST;
            r_good_thr <= GOOD_THR_RST;
            r_weak_thr <= WEAK_THR_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_MIN_CH:   r_min_ch   <= pwdata[6:0];
                REG_MAX_CH:   r_max_ch   <= pwdata[6:0];
                REG_DEF_CH:   r_def_ch   <= pwdata[6:0];
                REG_GOOD_THR: r_good_thr <= pwdata[7:0];
                REG_WEAK_THR: r_weak_thr <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (reg_sel)
            REG_MIN_CH:   prdata = {25'd0, r_min_ch};
            REG_MAX_CH:   prdata = {25'd0, r_max_ch};
            REG_DEF_CH:   prdata = {25'd0, r_def_ch};
            REG_GOOD_THR: prdata = {24'd0, r_good_thr};
            REG_WEAK_THR: prdata = {24'd0, r_weak_thr};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_min_channel = r_min_ch;
    assign o_max_channel = r_max_ch;
    assign o_good_thr    = r_good_thr;
    assign o_weak_thr    = r_weak_thr;

endmodule

/* rtl/csb_dp.sv */
// ============================================================================
// csb_dp
// Datapath: score memory with valid bits, saturating update and best scan.
// ============================================================================
module csb_dp
    import csb_pkg::*;
#(
    parameter int CHANNEL_COUNT = 128
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_channel,
    input  logic signed [7:0] i_rssi,
    input  logic [6:0]        i_min_channel,
    input  logic [6:0]        i_max_channel,
    input  logic [7:0]        i_good_thr,
    input  logic [7:0]        i_weak_thr,
    output logic              o_accepted,
    output logic signed [7:0] o_channel_score,
    output logic [6:0]        o_pick_channel,
    output logic signed [7:0] o_pick_score,
    output logic [6:0]        o_active_channel_out
);

    localparam int         CW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [8:0] CNT = 9'(CHANNEL_COUNT);

    // Score store and per-entry valid bits (an entry not yet written reads zero).
    logic [7:0]               r_mem [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] r_valid;
    logic [7:0]               r_rd_data;
    logic                     r_rd_valid;

    // Latched transaction and scoreboard state.
    logic [2:0]        r_op;
    logic [7:0]        r_ch;
    logic signed [7:0] r_rssi;
    logic [6:0]        r_current;
    logic [7:0]        r_scan;
    logic              r_pv;
    logic signed [7:0] r_best_sc;
    logic [6:0]        r_best_ch;

    // Result registers.
    logic              r_accepted;
    logic signed [7:0] r_ch_score;
    logic [6:0]        r_res_best_ch;
    logic signed [7:0] r_res_best_sc;

    logic              item_ok;
    logic              cur_ok;
    logic              in_range;
    logic              scan_issue;
    logic [CW-1:0]     rd_addr;
    logic [CW-1:0]     item_idx;
    logic [CW-1:0]     cur_idx;
    logic [CW-1:0]     scan_idx;
    logic signed [7:0] rd_score;
    logic signed [3:0] delta;
    logic signed [9:0] sum;
    logic signed [7:0] new_score;
    logic [7:0]        cur_ext;

    // Range checks against the configured window and the store depth.
    assign item_ok  = (r_ch >= {1'b0, i_min_channel}) && (r_ch <= {1'b0, i_max_channel})
                      && ({1'b0, r_ch} < CNT);
    assign cur_ext  = {1'b0, r_current};
    assign cur_ok   = {1'b0, cur_ext} < CNT;
    assign in_range = (r_scan <= {1'b0, i_max_channel}) && ({1'b0, r_scan} < CNT);

    assign o_sts.is_update = (r_op <= OP_SET_CH) && item_ok;
    assign o_sts.is_select = (r_op == OP_SELECT);
    assign o_sts.scan_busy = in_range | r_pv;

    assign scan_issue = i_cmd.scan_en & in_range;
    assign item_idx   = r_ch[CW-1:0];
    assign cur_idx    = cur_ext[CW-1:0];
    assign scan_idx   = r_scan[CW-1:0];

    // Read address select.
    always_comb begin
        if (i_cmd.rd_item) begin
            rd_addr = item_idx;
        end else if (i_cmd.rd_cur) begin
            rd_addr = cur_idx;
        end else begin
            rd_addr = scan_idx;
        end
    end

    assign rd_score = r_rd_valid ? $signed(r_rd_data) : 8'sd0;

    // Score step for the latched event.
    always_comb begin
        case (r_op)
            OP_TX_OK:   delta = STEP_TX_OK;
            OP_TX_FAIL: delta = STEP_TX_FAIL;
            OP_RX: begin
                if (r_rssi >= $signed(i_good_thr)) begin
                    delta = STEP_RX_GOOD;
                end else if (r_rssi <= $signed(i_weak_thr)) begin
                    delta = STEP_RX_WEAK;
                end else begin
                    delta = STEP_NONE;
                end
            end
            default:    delta = STEP_NONE;
        endcase
    end

    // Saturating add.
    assign sum = 10'(rd_score) + 10'(delta);
    always_comb begin
        if (sum > SCORE_HI) begin
            new_score = SCORE_HI[7:0];
        end else if (sum < SCORE_LO) begin
            new_score = SCORE_LO[7:0];
        end else begin
            new_score = sum[7:0];
        end
    end

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (i_cmd.res == RES_APPLY) begin
            r_mem[item_idx] <= new_score;
        end
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[rd_addr];
            if (i_cmd.res == RES_APPLY) begin
                r_valid[item_idx] <= 1'b1;
            end
        end
    end

    // Control state: current channel and scan pipeline flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current <= DEF_CH_RST;
            r_pv      <= 1'b0;
        end else begin
            r_pv <= scan_issue;
            if (i_cmd.res == RES_APPLY && r_op == OP_SET_CH) begin
                r_current <= r_ch[6:0];
            end
        end
    end

    // Transaction latch, scan counter and running best.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_ch   <= i_channel;
            r_rssi <= i_rssi;
        end
        if (i_cmd.rd_cur) begin
            r_scan <= {1'b0, i_min_channel};
        end else if (scan_issue) begin
            r_scan <= r_scan + 8'd1;
        end
        if (i_cmd.best_init) begin
            r_best_sc <= cur_ok ? rd_score : 8'sd0;
            r_best_ch <= r_current;
        end else if (i_cmd.scan_en && r_pv && (rd_score > r_best_sc)) begin
            // Strictly greater, so ties keep the earlier channel.
            r_best_sc <= rd_score;
            r_best_ch <= r_scan[6:0] - 7'd1;
        end
    end

    // Result capture.
    always_ff @(posedge i_clk) begin
        case (i_cmd.res)
            RES_REJECT: begin
                r_accepted    <= 1'b0;
                r_ch_score    <= 8'sd0;
                r_res_best_ch <= 7'd0;
                r_res_best_sc <= 8'sd0;
            end
            RES_APPLY: begin
                r_accepted    <= 1'b1;
                r_ch_score    <= new_score;
                r_res_best_ch <= 7'd0;
                r_res_best_sc <= 8'sd0;
            end
            RES_SELECT: begin
                r_accepted    <= 1'b1;
                r_ch_score    <= 8'sd0;
                r_res_best_ch <= r_best_ch;
                r_res_best_sc <= r_best_sc;
            end
            default: ;
        endcase
    end

    assign o_accepted           = r_accepted;
    assign o_channel_score      = r_ch_score;
    assign o_pick_channel       = r_res_best_ch;
    assign o_pick_score         = r_res_best_sc;
    assign o_active_channel_out = r_current;

endmodule

/* rtl/csb_ctrl.sv */
// ============================================================================
// csb_ctrl
// Controller state machine that sequences one transaction at a time.
// ============================================================================
module csb_ctrl
    import csb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output logic    o_done,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_APPLY,
        ST_SEL_INIT,
        ST_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '{load: 1'b0, rd_item: 1'b0, rd_cur: 1'b0, best_init: 1'b0,
                    scan_en: 1'b0, res: RES_IDLE};
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_sts.is_update) begin
                    o_cmd.rd_item = 1'b1;
                    n_state       = ST_APPLY;
                end else if (i_sts.is_select) begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = ST_SEL_INIT;
                end else begin
                    o_cmd.res = RES_REJECT;
                    n_done    = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_APPLY: begin
                o_cmd.res = RES_APPLY;
                n_done    = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_SEL_INIT: begin
                o_cmd.best_init = 1'b1;
                o_cmd.scan_en   = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_busy) begin
                    o_cmd.scan_en = 1'b1;
                end else begin
                    o_cmd.res = RES_SELECT;
                    n_done    = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

/* bench/csb_test_pkg.sv */
// ============================================================================
// csb_test_pkg
// Register indexes and spare opcode codes shared by the scoreboard testbench.
// ============================================================================
package csb_test_pkg;

    // Configuration registers, in address order (byte address is 4 * index).
    typedef enum int {
        REG_MIN_CHANNEL,
        REG_MAX_CHANNEL,
        REG_DEFAULT_CHANNEL,
        REG_GOOD_THRESHOLD,
        REG_WEAK_THRESHOLD
    } t_reg_index;

    // Opcodes the block does not define and must ignore.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

endpackage

/* bench/channel_quality_scoreboard_checker.sv */
// ============================================================================
// channel_quality_scoreboard_checker
// Watches the command, result and configuration ports of the scoreboard,
// keeps its own copy of the channel scores, predicts every result and
// compares it field by field with what the block reports.
// ============================================================================
module channel_quality_scoreboard_checker
    import csb_pkg::*;
    import csb_test_pkg::*;
#(
    parameter int CHANNEL_COUNT = 128
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_channel,
    input  logic signed [7:0] i_rssi,
    input  logic              i_done,
    input  logic              i_accepted,
    input  logic signed [7:0] i_channel_score,
    input  logic [6:0]        i_pick_channel,
    input  logic signed [7:0] i_pick_score,
    input  logic [6:0]        i_active_channel,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Score steps and saturation limits of the scoring rules.
    localparam int TX_OK_GAIN   = 2;
    localparam int TX_FAIL_LOSS = 8;
    localparam int RX_GOOD_GAIN = 1;
    localparam int RX_WEAK_LOSS = 2;
    localparam int SCORE_MAX    = 127;
    localparam int SCORE_MIN    = -127;

    typedef struct packed {
        logic              accepted;
        logic signed [7:0] channel_score;
        logic [6:0]        pick_channel;
        logic signed [7:0] pick_score;
        logic [6:0]        active_channel;
    } t_score_result;

    // Mirror of the block's state and registers.
    logic signed [7:0] score_mem [CHANNEL_COUNT];
    logic [6:0]        cur_chan;
    logic [6:0]        cfg_min_ch;
    logic [6:0]        cfg_max_ch;
    logic signed [7:0] cfg_good_thr;
    logic signed [7:0] cfg_weak_thr;

    t_score_result predicted_results [$];
    int            error_count   = 0;
    int            checked_count = 0;

    // Channels beyond the store read as zero.
    function automatic logic signed [7:0] stored_score(int ch);
        if (ch >= CHANNEL_COUNT) begin
            return '0;
        end
        return score_mem[ch];
    endfunction

    // Saturating update of one channel score.
    function automatic void bump_score(int ch, int delta);
        int s;
        s = int'(stored_score(ch)) + delta;
        if (s > SCORE_MAX) begin
            s = SCORE_MAX;
        end
        if (s < SCORE_MIN) begin
            s = SCORE_MIN;
        end
        score_mem[ch] = s[7:0];
    endfunction

    // Applies one event to the mirrored state and returns the expected result.
    function automatic t_score_result score_event(logic [2:0] op, logic [7:0] ch,
                                                  logic signed [7:0] rssi);
        t_score_result res;
        int            chi;
        logic          valid;
        res   = '0;
        chi   = int'(ch);
        valid = (chi >= int'(cfg_min_ch)) && (chi <= int'(cfg_max_ch))
                && (chi < CHANNEL_COUNT);
        if (op <= OP_SET_CH && valid) begin
            res.accepted = 1'b1;
            case (op)
                OP_TX_OK: begin
                    bump_score(chi, TX_OK_GAIN);
                end
                OP_TX_FAIL: begin
                    bump_score(chi, -TX_FAIL_LOSS);
                end
                OP_RX: begin
                    // The bonus wins when both thresholds hold.
                    if (rssi >= cfg_good_thr) begin
                        bump_score(chi, RX_GOOD_GAIN);
                    end else if (rssi <= cfg_weak_thr) begin
                        bump_score(chi, -RX_WEAK_LOSS);
                    end
                end
                default: begin
                    cur_chan = ch[6:0];
                end
            endcase
            res.channel_score = stored_score(chi);
        end else if (op == OP_SELECT) begin
            // The scan is seeded with the current channel, so ties keep it.
            res.accepted     = 1'b1;
            res.pick_channel = cur_chan;
            res.pick_score   = stored_score(int'(cur_chan));
            for (int c = int'(cfg_min_ch); c <= int'(cfg_max_ch) && c < CHANNEL_COUNT;
                 c++) begin
                if (stored_score(c) > res.pick_score) begin
                    res.pick_score   = stored_score(c);
                    res.pick_channel = c[6:0];
                end
            end
        end
        res.active_channel = cur_chan;
        return res;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                     want, got);
            error_count++;
        end
    endtask

    // Sampled at every rising edge: register writes, then results, then new transactions.
    always @(posedge i_clk) begin
        t_score_result want;
        t_score_result next_result;
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                score_mem[i] = '0;
            end
            cur_chan     = '0;
            cfg_min_ch   = MIN_CH_RST;
            cfg_max_ch   = MAX_CH_RST;
            cfg_good_thr = -8'sd75;
            cfg_weak_thr = -8'sd90;
            predicted_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (int'(i_paddr[APB_AW-1:2]))
                    REG_MIN_CHANNEL:     cfg_min_ch   = i_pwdata[6:0];
                    REG_MAX_CHANNEL:     cfg_max_ch   = i_pwdata[6:0];
                    // The default channel register does not feed the block; reset sets channel 0.
                    REG_DEFAULT_CHANNEL: ;
                    REG_GOOD_THRESHOLD:  cfg_good_thr = i_pwdata[7:0];
                    REG_WEAK_THRESHOLD:  cfg_weak_thr = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t ns: result with no transaction outstanding", $time);
                    error_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("accepted", int'(want.accepted), int'(i_accepted));
                    check_field("channel_score", int'(want.channel_score),
                                int'(i_channel_score));
                    check_field("pick_channel", int'(want.pick_channel),
                                int'(i_pick_channel));
                    check_field("pick_score", int'(want.pick_score), int'(i_pick_score));
                    check_field("active_channel", int'(want.active_channel),
                                int'(i_active_channel));
                    checked_count++;
                end
            end
            if (i_start && !i_busy) begin
                next_result = score_event(i_opcode, i_channel, i_rssi);
                predicted_results.push_back(next_result);
            end
        end
        o_errors  <= error_count;
        o_pending <= predicted_results.size();
        o_checked <= checked_count;
    end

endmodule

/* bench/channel_quality_scoreboard_test.sv */
// ============================================================================
// channel_quality_scoreboard_test
// Drives scoring, set-channel, select and unused-opcode transactions into the
// scoreboard under a series of register settings and sender idle rates, and
// reports the verdict from the checker's mismatch and outstanding counts.
// ============================================================================
module channel_quality_scoreboard_test;
    import csb_pkg::*;
    import csb_test_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNEL_COUNT   = 128;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 117;
    localparam int DRAIN_CYCLES    = CHANNEL_COUNT + 16;
    localparam int RANDOM_PICK     = 999;

    // Opcode mixes: balanced, mostly gains, mostly losses.
    localparam int MIX_EVEN = 0;
    localparam int MIX_GAIN = 1;
    localparam int MIX_LOSS = 2;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        i_opcode;
    logic [7:0]        i_channel;
    logic signed [7:0] i_rssi;
    logic              o_done;
    logic              o_accepted;
    logic signed [7:0] o_channel_score;
    logic [6:0]        o_pick_channel;
    logic signed [7:0] o_pick_score;
    logic [6:0]        o_active_channel_out;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int err_count;
    int pending;
    int checked;
    int item_count = 0;

    // Register settings per phase; extremes, overlapping thresholds, an empty
    // window and single-channel windows that drive scores into saturation.
    int phase_min  [PHASE_COUNT] = '{0, 0, 10, 127, 127, 50, 0, RANDOM_PICK};
    int phase_max  [PHASE_COUNT] = '{100, 127, 20, 127, 127, 40, 0, RANDOM_PICK};
    int phase_good [PHASE_COUNT] = '{-75, 127, -50, -128, -128, -75, -75, RANDOM_PICK};
    int phase_weak [PHASE_COUNT] = '{-90, -128, -40, 127, 127, -90, -90, RANDOM_PICK};
    int phase_mix  [PHASE_COUNT] = '{MIX_EVEN, MIX_GAIN, MIX_EVEN, MIX_GAIN,
                                     MIX_LOSS, MIX_EVEN, MIX_LOSS, MIX_EVEN};
    int phase_idle [PHASE_COUNT] = '{0, 61, 23, 0, 61, 23, 0, 61};

    // Register values as last written, used to aim channels and RSSI values.
    int min_ch;
    int max_ch;
    int good_thr;
    int weak_thr;

    channel_quality_scoreboard #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_opcode             (i_opcode),
        .i_channel            (i_channel),
        .i_rssi               (i_rssi),
        .o_done               (o_done),
        .o_accepted           (o_accepted),
        .o_channel_score      (o_channel_score),
        .o_pick_channel       (o_pick_channel),
        .o_pick_score         (o_pick_score),
        .o_active_channel_out (o_active_channel_out),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    channel_quality_scoreboard_checker #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) score_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (i_opcode),
        .i_channel        (i_channel),
        .i_rssi           (i_rssi),
        .i_done           (o_done),
        .i_accepted       (o_accepted),
        .i_channel_score  (o_channel_score),
        .i_pick_channel   (o_pick_channel),
        .i_pick_score     (o_pick_score),
        .i_active_channel (o_active_channel_out),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_errors         (err_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #(20_000_000);
        $display("Run limit reached with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Waits until no transaction is in flight or outstanding.
    task automatic wait_idle();
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    // One register write: setup cycle, then access until pready.
    task automatic write_reg(t_reg_index idx, int value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(int'(idx) * 4);
        pwdata  <= {24'd0, value[7:0]};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Issues one transaction after an optional random gap; returns at the
    // accepting edge with start still high.
    task automatic send_item(logic [2:0] op, logic [7:0] ch, logic [7:0] rssi,
                             int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start     <= 1'b1;
        i_opcode  <= op;
        i_channel <= ch;
        i_rssi    <= rssi;
        do @(posedge i_clk); while (busy);
        item_count++;
    endtask

    // Random transaction: opcode from the phase mix, channel mostly inside the
    // window, RSSI often next to a threshold.
    task automatic send_random(int mix, int idle_pct);
        logic [2:0] op;
        logic [7:0] ch;
        logic [7:0] rssi;
        int         r;
        int         v;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end else if (r < 14) begin
            op = OP_SELECT;
        end else if (r < 22) begin
            op = OP_SET_CH;
        end else begin
            r = $urandom_range(0, 99);
            case (mix)
                MIX_GAIN: op = (r < 70) ? OP_TX_OK : (r < 80) ? OP_TX_FAIL : OP_RX;
                MIX_LOSS: op = (r < 10) ? OP_TX_OK : (r < 80) ? OP_TX_FAIL : OP_RX;
                default:  op = (r < 30) ? OP_TX_OK : (r < 60) ? OP_TX_FAIL : OP_RX;
            endcase
        end
        if (min_ch <= max_ch && $urandom_range(0, 3) != 0) begin
            ch = 8'($urandom_range(min_ch, max_ch));
        end else begin
            ch = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) < 4) begin
            v = ($urandom_range(0, 1) != 0) ? good_thr : weak_thr;
            v = v + int'($urandom_range(0, 2)) - 1;
            rssi = v[7:0];
        end else begin
            rssi = 8'($urandom_range(0, 255));
        end
        send_item(op, ch, rssi, idle_pct);
    endtask

    // Stimulus and verdict.
    initial begin
        int new_min;
        int new_max;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_opcode  = OP_TX_OK;
        i_channel = '0;
        i_rssi    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        min_ch    = 0;
        max_ch    = 100;
        good_thr  = -75;
        weak_thr  = -90;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset register values.
        send_item(OP_TX_OK, 8'd0, 8'h00, 0);
        send_item(OP_TX_OK, 8'd100, 8'h00, 0);
        send_item(OP_TX_FAIL, 8'd0, 8'h00, 0);
        send_item(OP_RX, 8'd100, 8'h7f, 0);
        send_item(OP_RX, 8'd100, 8'h80, 23);
        // RSSI exactly on each threshold, then between them.
        send_item(OP_RX, 8'd5, 8'hb5, 0);
        send_item(OP_RX, 8'd5, 8'ha6, 0);
        send_item(OP_RX, 8'd5, 8'hb0, 23);
        // Channels just above the window and beyond the store, then a select.
        send_item(OP_TX_OK, 8'd101, 8'h00, 0);
        send_item(OP_TX_FAIL, 8'd255, 8'hff, 0);
        send_item(OP_SET_CH, 8'd128, 8'h00, 0);
        send_item(OP_SELECT, 8'hff, 8'h00, 0);
        // Tie: channel 3 and channel 100 both reach 2; select from 100 keeps it.
        send_item(OP_TX_OK, 8'd3, 8'h00, 0);
        send_item(OP_RX, 8'd100, 8'h7f, 0);
        send_item(OP_SET_CH, 8'd100, 8'h00, 0);
        send_item(OP_SELECT, 8'd0, 8'h55, 23);
        send_item(OP_SET_CH, 8'd0, 8'h00, 0);
        send_item(OP_SELECT, 8'd0, 8'h00, 0);
        // Unused opcodes are ignored.
        send_item(OP_UNUSED_FIRST, 8'd50, 8'hff, 0);
        send_item(OP_UNUSED_MID, 8'd50, 8'hff, 0);
        send_item(OP_UNUSED_LAST, 8'd50, 8'hff, 0);
        start <= 1'b0;

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            new_min  = (phase_min[p] == RANDOM_PICK) ? $urandom_range(0, 127) : phase_min[p];
            new_max  = (phase_max[p] == RANDOM_PICK) ? $urandom_range(0, 127) : phase_max[p];
            good_thr = (phase_good[p] == RANDOM_PICK) ? int'($urandom_range(0, 255)) - 128
                                                      : phase_good[p];
            weak_thr = (phase_weak[p] == RANDOM_PICK) ? int'($urandom_range(0, 255)) - 128
                                                      : phase_weak[p];
            min_ch   = new_min;
            max_ch   = new_max;
            write_reg(REG_MIN_CHANNEL, min_ch);
            write_reg(REG_MAX_CHANNEL, max_ch);
            write_reg(REG_DEFAULT_CHANNEL, $urandom_range(0, 127));
            write_reg(REG_GOOD_THRESHOLD, good_thr);
            write_reg(REG_WEAK_THRESHOLD, weak_thr);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_random(phase_mix[p], phase_idle[p]);
            end
            start <= 1'b0;
        end

        // Drain, then allow for a full-window select latency.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions over %0d register settings, %0d results compared.",
                 item_count, PHASE_COUNT + 1, checked);
        $display("Covered all opcodes, window edges, threshold overlap and saturation.");
        if (err_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (pending != 0) begin
                $display("%0t ns: %0d expected results never arrived", $time, pending);
            end
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
